// ===== src/srsm_pkg.sv =====
// Package: shared constants and types of the stream rate and sequence monitor.
`timescale 1ns / 1ps

package srsm_pkg;

   // Block configuration.
   localparam int WINDOW      = 10;
   localparam int NUM_STREAMS = 4;

   // Register file layout: a low and a high period register per stream.
   localparam int CFG_STREAMS = 4;
   localparam int NUM_CFG     = 2 * CFG_STREAMS;
   localparam int CSR_IDX_W   = $clog2(NUM_CFG);
   localparam int CSR_DATA_W  = 24;
   localparam int CFG_SEL_W   = $clog2(CFG_STREAMS);

   // Field widths.
   localparam int SID_W  = 2;
   localparam int WORD_W = 32;

   // Derived widths.
   localparam int SIDX_W     = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
   localparam int SLOT_W     = $clog2(WINDOW);
   localparam int RING_DEPTH = NUM_STREAMS * WINDOW;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int BOUND_W    = CSR_DATA_W + $clog2(WINDOW);

   localparam logic [WORD_W-1:0] WORD_MAX = '1;

   // Payload of one transaction between the front end and the window check.
   typedef struct packed {
      logic [SID_W-1:0]   stream_id;
      logic [WORD_W-1:0]  arrival_tick;
      logic               checked;
      logic               seq_skip;
      logic [WORD_W-1:0]  previous_seq;
      logic [WORD_W-1:0]  stream_msg_count;
      logic [WORD_W-1:0]  all_msg_count;
      logic [BOUND_W-1:0] low_bound;
      logic [BOUND_W-1:0] high_bound;
   } stage_type;

   // Saturating increment of a 32-bit count.
   function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] value);
      logic [WORD_W-1:0] result;
      result = (value == WORD_MAX) ? value : value + WORD_W'(1);
      return result;
   endfunction

endpackage

// ===== src/srsm_if.sv =====
// Interfaces: the message request channel and the result response channel.
`timescale 1ns / 1ps

interface srsm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [srsm_pkg::SID_W-1:0]           stream_id;
   logic [srsm_pkg::WORD_W-1:0]          arrival_tick;
   logic [srsm_pkg::WORD_W-1:0]          seq_number;

   modport source (output valid, output stream_id, output arrival_tick,
                   output seq_number, input ready);
   modport sink   (input valid, input stream_id, input arrival_tick,
                   input seq_number, output ready);
endinterface

interface srsm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        rate_fault;
   logic                        window_checked;
   logic [srsm_pkg::WORD_W-1:0] window_span;
   logic                        seq_skip;
   logic [srsm_pkg::WORD_W-1:0] previous_seq;
   logic [srsm_pkg::WORD_W-1:0] stream_msg_count;
   logic [srsm_pkg::WORD_W-1:0] stream_fault_count;
   logic [srsm_pkg::WORD_W-1:0] all_msg_count;
   logic [srsm_pkg::WORD_W-1:0] all_fault_count;

   modport source (output valid, output rate_fault, output window_checked,
                   output window_span, output seq_skip, output previous_seq,
                   output stream_msg_count, output stream_fault_count,
                   output all_msg_count, output all_fault_count, input ready);
   modport sink   (input valid, input rate_fault, input window_checked,
                   input window_span, input seq_skip, input previous_seq,
                   input stream_msg_count, input stream_fault_count,
                   input all_msg_count, input all_fault_count, output ready);
endinterface

// ===== src/srsm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module srsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/srsm_front.sv =====
// Front end: bound registers, per-stream sequence and count state, ring addressing.
`timescale 1ns / 1ps

module srsm_front (
   input  logic                                clock,
   input  logic                                reset,
   srsm_req_if.sink                            req,
   input  logic                                advance,
   input  logic                                csr_we,
   input  logic [srsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srsm_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                ring_wr_en,
   output logic [srsm_pkg::RING_AW-1:0]        ring_wr_addr,
   output logic [srsm_pkg::WORD_W-1:0]         ring_wr_data,
   output logic [srsm_pkg::RING_AW-1:0]        ring_rd_addr,
   output logic                                stage_valid,
   output srsm_pkg::stage_type                 stage
);

   // Bound registers.
   logic [srsm_pkg::CSR_DATA_W-1:0] low_ff  [srsm_pkg::CFG_STREAMS];
   logic [srsm_pkg::CSR_DATA_W-1:0] high_ff [srsm_pkg::CFG_STREAMS];

   // Per-stream state.
   logic [srsm_pkg::SLOT_W-1:0] slot_ff     [srsm_pkg::NUM_STREAMS];
   logic [srsm_pkg::WORD_W-1:0] msg_cnt_ff  [srsm_pkg::NUM_STREAMS];
   logic [srsm_pkg::WORD_W-1:0] last_seq_ff [srsm_pkg::NUM_STREAMS];
   logic                        seen_ff     [srsm_pkg::NUM_STREAMS];
   logic [srsm_pkg::WORD_W-1:0] all_msg_ff;

   logic                        stage_valid_ff;
   srsm_pkg::stage_type         stage_ff;

   logic                               in_range;
   logic                               take;
   logic [srsm_pkg::SIDX_W-1:0]        sidx;
   logic [srsm_pkg::CFG_SEL_W-1:0]     csel;
   logic [srsm_pkg::CFG_SEL_W-1:0]     wsel;
   logic [srsm_pkg::SLOT_W-1:0]        slot_cur;
   logic [srsm_pkg::SLOT_W-1:0]        slot_in;
   logic [srsm_pkg::WORD_W-1:0]        msg_cnt_in;
   logic [srsm_pkg::WORD_W-1:0]        all_msg_in;
   logic [srsm_pkg::RING_AW-1:0]       ring_base;
   srsm_pkg::stage_type                stage_in;

   assign req.ready = advance;
   assign in_range  = (32'(req.stream_id) < srsm_pkg::NUM_STREAMS);
   assign take      = req.valid && advance && in_range;
   assign sidx      = req.stream_id[srsm_pkg::SIDX_W-1:0];
   assign csel      = req.stream_id[srsm_pkg::CFG_SEL_W-1:0];
   assign wsel      = csr_index[srsm_pkg::CSR_IDX_W-1:1];

   // Bound registers; odd indexes hold the high period of a stream.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < srsm_pkg::CFG_STREAMS; s++) begin
            low_ff[s]  <= '0;
            high_ff[s] <= '1;
         end
      end else if (csr_we && (32'(csr_index) < srsm_pkg::NUM_CFG)) begin
         if (csr_index[0]) begin
            high_ff[wsel] <= csr_data;
         end else begin
            low_ff[wsel] <= csr_data;
         end
      end
   end

   // Next per-stream state for the stream of the current transaction.
   always_comb begin
      slot_cur   = slot_ff[sidx];
      slot_in    = (32'(slot_cur) == srsm_pkg::WINDOW - 1) ? '0
                                                           : slot_cur + 1'b1;
      msg_cnt_in = srsm_pkg::sat_inc(msg_cnt_ff[sidx]);
      all_msg_in = srsm_pkg::sat_inc(all_msg_ff);
      ring_base  = srsm_pkg::RING_AW'(32'(sidx) * srsm_pkg::WINDOW);
   end

   // Ring access: write the new tick at the current slot, read the oldest one.
   assign ring_wr_en   = take;
   assign ring_wr_addr = ring_base + srsm_pkg::RING_AW'(slot_cur);
   assign ring_wr_data = req.arrival_tick;
   assign ring_rd_addr = ring_base + srsm_pkg::RING_AW'(slot_in);

   // Stage payload: sequence check, counts and scaled bounds.
   always_comb begin
      stage_in.stream_id        = req.stream_id;
      stage_in.arrival_tick     = req.arrival_tick;
      stage_in.checked          = (msg_cnt_in > 32'(srsm_pkg::WINDOW));
      stage_in.seq_skip         = seen_ff[sidx] &&
                                  ((last_seq_ff[sidx] + 32'd1) != req.seq_number);
      stage_in.previous_seq     = seen_ff[sidx] ? last_seq_ff[sidx] : '0;
      stage_in.stream_msg_count = msg_cnt_in;
      stage_in.all_msg_count    = all_msg_in;
      stage_in.low_bound        = srsm_pkg::BOUND_W'(low_ff[csel]) *
                                  srsm_pkg::BOUND_W'(srsm_pkg::WINDOW - 1);
      stage_in.high_bound       = srsm_pkg::BOUND_W'(high_ff[csel]) *
                                  srsm_pkg::BOUND_W'(srsm_pkg::WINDOW - 1);
   end

   // Per-stream state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < srsm_pkg::NUM_STREAMS; s++) begin
            slot_ff[s]     <= '0;
            msg_cnt_ff[s]  <= '0;
            last_seq_ff[s] <= '0;
            seen_ff[s]     <= 1'b0;
         end
         all_msg_ff <= '0;
      end else if (take) begin
         slot_ff[sidx]     <= slot_in;
         msg_cnt_ff[sidx]  <= msg_cnt_in;
         last_seq_ff[sidx] <= req.seq_number;
         seen_ff[sidx]     <= 1'b1;
         all_msg_ff        <= all_msg_in;
      end
   end

   // Stage register, paced by the pipeline advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

endmodule

// ===== src/srsm_check.sv =====
// Window check: span and bound compare, fault counters and the result register.
`timescale 1ns / 1ps

module srsm_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          stage_valid,
   input  srsm_pkg::stage_type           stage,
   input  logic [srsm_pkg::WORD_W-1:0]   oldest_tick,
   output logic                          advance,
   srsm_rsp_if.source                    rsp
);

   logic [srsm_pkg::WORD_W-1:0] fault_cnt_ff [srsm_pkg::NUM_STREAMS];
   logic [srsm_pkg::WORD_W-1:0] all_fault_ff;

   logic                        out_valid_ff;
   logic                        rate_fault_ff;
   logic                        checked_ff;
   logic [srsm_pkg::WORD_W-1:0] span_ff;
   logic                        skip_ff;
   logic [srsm_pkg::WORD_W-1:0] prev_ff;
   logic [srsm_pkg::WORD_W-1:0] msg_cnt_ff;
   logic [srsm_pkg::WORD_W-1:0] fault_cnt_out_ff;
   logic [srsm_pkg::WORD_W-1:0] all_msg_ff;
   logic [srsm_pkg::WORD_W-1:0] all_fault_out_ff;

   logic                        fire;
   logic [srsm_pkg::SIDX_W-1:0] sidx;
   logic [srsm_pkg::WORD_W-1:0] span_raw;
   logic                        fault;
   logic [srsm_pkg::WORD_W-1:0] fault_cnt_in;
   logic [srsm_pkg::WORD_W-1:0] all_fault_in;

   // The pipeline moves when the result register is empty or being taken.
   assign advance = !out_valid_ff || rsp.ready;
   assign fire    = stage_valid && advance;
   assign sidx    = stage.stream_id[srsm_pkg::SIDX_W-1:0];

   // Span over the window and the exact average-period test.
   always_comb begin
      span_raw     = stage.arrival_tick - oldest_tick;
      fault        = stage.checked &&
                     ((span_raw < 32'(stage.low_bound)) ||
                      (span_raw > 32'(stage.high_bound)));
      fault_cnt_in = fault ? srsm_pkg::sat_inc(fault_cnt_ff[sidx]) : fault_cnt_ff[sidx];
      all_fault_in = fault ? srsm_pkg::sat_inc(all_fault_ff) : all_fault_ff;
   end

   // Fault counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < srsm_pkg::NUM_STREAMS; s++) begin
            fault_cnt_ff[s] <= '0;
         end
         all_fault_ff <= '0;
      end else if (fire) begin
         fault_cnt_ff[sidx] <= fault_cnt_in;
         all_fault_ff       <= all_fault_in;
      end
   end

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stage_valid;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         rate_fault_ff    <= fault;
         checked_ff       <= stage.checked;
         span_ff          <= stage.checked ? span_raw : '0;
         skip_ff          <= stage.seq_skip;
         prev_ff          <= stage.previous_seq;
         msg_cnt_ff       <= stage.stream_msg_count;
         fault_cnt_out_ff <= fault_cnt_in;
         all_msg_ff       <= stage.all_msg_count;
         all_fault_out_ff <= all_fault_in;
      end
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.rate_fault         = rate_fault_ff;
   assign rsp.window_checked     = checked_ff;
   assign rsp.window_span        = span_ff;
   assign rsp.seq_skip           = skip_ff;
   assign rsp.previous_seq       = prev_ff;
   assign rsp.stream_msg_count   = msg_cnt_ff;
   assign rsp.stream_fault_count = fault_cnt_out_ff;
   assign rsp.all_msg_count      = all_msg_ff;
   assign rsp.all_fault_count    = all_fault_out_ff;

endmodule

// ===== src/stream_rate_and_sequence_monitor.sv =====
// Top level of the stream rate and sequence monitor.
`timescale 1ns / 1ps

// The monitor takes one message transaction per clock cycle while the pipeline
// is not stalled and returns one result transaction for each message whose
// stream id is in range, in order. A result passes the stage register and then
// the result register: the accepting edge updates the per-stream sequence and
// count state and reads the oldest timestamp of the stream's window from the
// tick ring memory while the new timestamp is written; the edge that moves the
// stage on does the span compare, updates the fault counters and loads the
// result register. The rate of one transaction per cycle, while not stalled, is
// set by the single write and single read port of the tick ring; both ports are
// used once per message. While a result waits, the input stalls. The newest and
// oldest slots of a stream always differ, and a slot written in one cycle is
// readable in the next, so no forwarding is needed. The ring is not cleared
// after reset; its entries are only used once the stream has filled its window.
// Bound registers should be written while no message is in flight.
module stream_rate_and_sequence_monitor (
   input  logic                               clock,
   input  logic                               reset,
   srsm_req_if.sink                           req_chan,
   srsm_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [srsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srsm_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic                          advance;
   logic                          ring_wr_en;
   logic [srsm_pkg::RING_AW-1:0]  ring_wr_addr;
   logic [srsm_pkg::WORD_W-1:0]   ring_wr_data;
   logic [srsm_pkg::RING_AW-1:0]  ring_rd_addr;
   logic [srsm_pkg::WORD_W-1:0]   oldest_tick;
   logic                          stage_valid;
   srsm_pkg::stage_type           stage;

   // Bound registers, per-stream state and ring addressing.
   srsm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .advance      (advance),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .ring_wr_en   (ring_wr_en),
      .ring_wr_addr (ring_wr_addr),
      .ring_wr_data (ring_wr_data),
      .ring_rd_addr (ring_rd_addr),
      .stage_valid  (stage_valid),
      .stage        (stage)
   );

   // Tick ring: the last timestamps of every stream.
   srsm_ram #(
      .WIDTH (srsm_pkg::WORD_W),
      .DEPTH (srsm_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (ring_wr_en),
      .rd_addr (ring_rd_addr),
      .rd_data (oldest_tick)
   );

   // Window check and result register.
   srsm_check u_check (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .oldest_tick (oldest_tick),
      .advance     (advance),
      .rsp         (rsp_chan)
   );

endmodule
